### rtl/core/hvtrim_pkg.sv
// Shared types and constants of the hover trim calibration sequencer.
// No dependencies; every other file of the block refers to this package.
package hvtrim_pkg;

  // Field widths
  localparam int unsigned DRV_W      = 16;  // heights, angles, drives
  localparam int unsigned CORR_W     = 17;  // corrected angles
  localparam int unsigned TIME_W     = 32;  // millisecond time
  localparam int unsigned NUM_MOTORS = 4;

  // Default sample limit
  localparam int unsigned MAX_SAMPLES_DEF = 4096;

  // Configuration port
  localparam int unsigned APB_ADDR_W = 5;
  localparam int unsigned APB_DATA_W = 32;

  // Request kind carried in tuser
  localparam logic ACT_TICK    = 1'b0;
  localparam logic ACT_RESTART = 1'b1;

  typedef enum logic [1:0] {
    PH_WAIT   = 2'd0,
    PH_STAB   = 2'd1,
    PH_SAMPLE = 2'd2,
    PH_DONE   = 2'd3
  } phase_e;

  // Register map, index = byte address / 4
  typedef enum logic [2:0] {
    REG_TRIGGER_HEIGHT = 3'd0,
    REG_STABLE_WAIT    = 3'd1,
    REG_SAMPLE_WINDOW  = 3'd2,
    REG_BUZZER_MS      = 3'd3,
    REG_DEF_ROLL       = 3'd4,
    REG_DEF_PITCH      = 3'd5,
    REG_DEF_HOVER_F    = 3'd6,
    REG_DEF_HOVER_B    = 3'd7
  } reg_idx_e;

  // Order in which the six averages go through the divider
  typedef enum logic [2:0] {
    QSEL_ROLL  = 3'd0,
    QSEL_PITCH = 3'd1,
    QSEL_LF    = 3'd2,
    QSEL_RF    = 3'd3,
    QSEL_LB    = 3'd4,
    QSEL_RB    = 3'd5
  } qsel_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_EMIT
  } ctrl_state_e;

  typedef struct packed {
    logic signed [DRV_W-1:0] trigger_height;
    logic [DRV_W-1:0]        stable_wait_ms;
    logic [DRV_W-1:0]        sample_window_ms;
    logic [DRV_W-1:0]        buzzer_ms;
    logic signed [DRV_W-1:0] def_roll;
    logic signed [DRV_W-1:0] def_pitch;
    logic [2*DRV_W-1:0]      def_hover_front;
    logic [2*DRV_W-1:0]      def_hover_back;
  } cfg_t;

  localparam cfg_t CFG_RST = '{
    trigger_height:   16'sd80,
    stable_wait_ms:   16'd3000,
    sample_window_ms: 16'd1000,
    buzzer_ms:        16'd100,
    def_roll:         16'sd0,
    def_pitch:        16'sd0,
    def_hover_front:  32'd0,
    def_hover_back:   32'd0
  };

  // Input request, last declared field in the lowest bits
  typedef struct packed {
    logic [5:0]              pad;
    logic signed [DRV_W-1:0] motor_rb;
    logic signed [DRV_W-1:0] motor_lb;
    logic signed [DRV_W-1:0] motor_rf;
    logic signed [DRV_W-1:0] motor_lf;
    logic signed [DRV_W-1:0] pitch;
    logic signed [DRV_W-1:0] roll;
    logic signed [DRV_W-1:0] height_cm;
    logic                    armed;
    logic                    in_normal_flight;
    logic [TIME_W-1:0]       now_ms;
  } in_t;

  // Result, last declared field in the lowest bits
  typedef struct packed {
    logic                     pad;
    logic                     wide_integral_limit;
    logic                     clear_integrals;
    logic signed [DRV_W-1:0]  hover_rb;
    logic signed [DRV_W-1:0]  hover_lb;
    logic signed [DRV_W-1:0]  hover_rf;
    logic signed [DRV_W-1:0]  hover_lf;
    logic signed [CORR_W-1:0] corrected_pitch;
    logic signed [CORR_W-1:0] corrected_roll;
    logic signed [DRV_W-1:0]  pitch_trim;
    logic signed [DRV_W-1:0]  roll_trim;
    logic                     buzzer;
    phase_e                   phase;
  } out_t;

  localparam int unsigned IN_TDATA_W  = $bits(in_t);
  localparam int unsigned OUT_TDATA_W = $bits(out_t);

  // Controller to datapath
  typedef struct packed {
    logic  capture;
    logic  eval;
    logic  div_start;
    qsel_e qsel;
    logic  div_store;
    logic  out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_div;
    logic div_done;
  } sts_t;

endpackage

### rtl/core/hvtrim_div.sv
// Shared iterative signed divider: one quotient bit per cycle, truncates toward zero.
// Depends on hvtrim_pkg for the quotient width.
module hvtrim_div #(
  parameter int unsigned NW = 29,  // dividend width
  parameter int unsigned DW = 13   // divisor width
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic signed [NW-1:0]            dividend_i,
  input  logic [DW-1:0]                   divisor_i,
  output logic                            done_o,
  output logic signed [hvtrim_pkg::DRV_W-1:0] quotient_o
);

  localparam int unsigned CNT_W = $clog2(NW + 1);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [NW-1:0]    quo_q;
  logic [DW-1:0]    rem_q;
  logic [DW-1:0]    dvs_q;
  logic             neg_q;

  logic [NW-1:0]    mag;
  logic [DW:0]      trial;
  logic             fits;
  logic [DW:0]      diff;

  // Magnitude of the dividend; the most negative value still fits unsigned
  assign mag = dividend_i[NW-1] ? NW'(-dividend_i) : NW'(dividend_i);

  // One restoring step
  assign trial = {rem_q, quo_q[NW-1]};
  assign fits  = (trial >= {1'b0, dvs_q});
  assign diff  = trial - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CNT_W'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(NW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Operand and partial result registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= mag;
      rem_q <= '0;
      dvs_q <= divisor_i;
      neg_q <= dividend_i[NW-1];
    end else if (busy_q) begin
      rem_q <= fits ? diff[DW-1:0] : trial[DW-1:0];
      quo_q <= {quo_q[NW-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? -quo_q[hvtrim_pkg::DRV_W-1:0] : quo_q[hvtrim_pkg::DRV_W-1:0];

endmodule

### rtl/core/hvtrim_dp.sv
// Datapath: captured request, calibration state, accumulators, divider and result register.
// Depends on hvtrim_pkg and hvtrim_div; driven by commands from hvtrim_ctrl.
module hvtrim_dp #(
  parameter int unsigned MAX_SAMPLES = hvtrim_pkg::MAX_SAMPLES_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  hvtrim_pkg::cfg_t                      cfg_i,
  input  hvtrim_pkg::cmd_t                      cmd_i,
  output hvtrim_pkg::sts_t                      sts_o,
  input  logic [hvtrim_pkg::IN_TDATA_W-1:0]     in_data_i,
  input  logic                                  in_action_i,
  output logic [hvtrim_pkg::OUT_TDATA_W-1:0]    out_data_o
);

  localparam int unsigned CW = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned SW = hvtrim_pkg::DRV_W + CW;
  localparam int unsigned NM = hvtrim_pkg::NUM_MOTORS;
  localparam int unsigned DRV_W = hvtrim_pkg::DRV_W;
  localparam int unsigned TIME_W = hvtrim_pkg::TIME_W;
  localparam int unsigned CORR_W = hvtrim_pkg::CORR_W;

  // Captured request
  hvtrim_pkg::in_t in_q;
  logic            act_q;

  // Calibration state
  hvtrim_pkg::phase_e      phase_q, phase_d;
  logic [TIME_W-1:0]       start_q, start_d;
  logic [CW-1:0]           count_q, count_d;
  logic signed [SW-1:0]    roll_sum_q, roll_sum_d;
  logic signed [SW-1:0]    pitch_sum_q, pitch_sum_d;
  logic signed [SW-1:0]    msum_q [NM];
  logic signed [SW-1:0]    msum_d [NM];
  logic signed [DRV_W-1:0] roll_off_q, roll_off_d;
  logic signed [DRV_W-1:0] pitch_off_q, pitch_off_d;
  logic signed [DRV_W-1:0] hover_q [NM];
  logic signed [DRV_W-1:0] hover_d [NM];
  logic                    buz_q, buz_d;
  logic [TIME_W-1:0]       buz_dl_q, buz_dl_d;
  logic                    wide_q, wide_d;
  logic                    clear_q, clear_d;

  hvtrim_pkg::out_t        out_q;

  logic signed [DRV_W-1:0] motor_in [NM];
  logic [TIME_W-1:0]       elapsed;
  logic                    win_end;
  logic signed [SW-1:0]    dvd;
  logic                    div_done;
  logic signed [DRV_W-1:0] quo;

  assign motor_in[0] = in_q.motor_lf;
  assign motor_in[1] = in_q.motor_rf;
  assign motor_in[2] = in_q.motor_lb;
  assign motor_in[3] = in_q.motor_rb;

  assign elapsed = in_q.now_ms - start_q;

  // Request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      in_q  <= hvtrim_pkg::in_t'(in_data_i);
      act_q <= in_action_i;
    end
  end

  // Tick update
  always_comb begin
    phase_d     = phase_q;
    start_d     = start_q;
    count_d     = count_q;
    roll_sum_d  = roll_sum_q;
    pitch_sum_d = pitch_sum_q;
    msum_d      = msum_q;
    roll_off_d  = roll_off_q;
    pitch_off_d = pitch_off_q;
    hover_d     = hover_q;
    buz_d       = buz_q;
    buz_dl_d    = buz_dl_q;
    wide_d      = wide_q;
    clear_d     = 1'b0;
    win_end     = 1'b0;

    if (act_q == hvtrim_pkg::ACT_RESTART) begin
      phase_d     = hvtrim_pkg::PH_WAIT;
      start_d     = '0;
      count_d     = '0;
      roll_sum_d  = '0;
      pitch_sum_d = '0;
      for (int i = 0; i < NM; i++) begin
        msum_d[i] = '0;
      end
      roll_off_d  = cfg_i.def_roll;
      pitch_off_d = cfg_i.def_pitch;
      hover_d[0]  = cfg_i.def_hover_front[DRV_W-1:0];
      hover_d[1]  = cfg_i.def_hover_front[2*DRV_W-1:DRV_W];
      hover_d[2]  = cfg_i.def_hover_back[DRV_W-1:0];
      hover_d[3]  = cfg_i.def_hover_back[2*DRV_W-1:DRV_W];
      buz_d       = 1'b0;
      buz_dl_d    = '0;
      wide_d      = 1'b1;
    end else begin
      // plain unsigned compare: a wrapped deadline ends at once
      if (buz_q && (in_q.now_ms >= buz_dl_q)) begin
        buz_d = 1'b0;
      end
      case (phase_q)
        hvtrim_pkg::PH_WAIT: begin
          if (in_q.in_normal_flight && in_q.armed &&
              (in_q.height_cm >= cfg_i.trigger_height)) begin
            phase_d = hvtrim_pkg::PH_STAB;
            start_d = in_q.now_ms;
          end
        end
        hvtrim_pkg::PH_STAB: begin
          if (elapsed >= TIME_W'(cfg_i.stable_wait_ms)) begin
            phase_d     = hvtrim_pkg::PH_SAMPLE;
            start_d     = in_q.now_ms;
            count_d     = '0;
            roll_sum_d  = '0;
            pitch_sum_d = '0;
            for (int i = 0; i < NM; i++) begin
              msum_d[i] = '0;
            end
            buz_d    = 1'b1;
            buz_dl_d = in_q.now_ms + TIME_W'(cfg_i.buzzer_ms);
          end
        end
        hvtrim_pkg::PH_SAMPLE: begin
          // samples beyond the limit are dropped
          if (count_q < CW'(MAX_SAMPLES)) begin
            roll_sum_d  = roll_sum_q + SW'(in_q.roll);
            pitch_sum_d = pitch_sum_q + SW'(in_q.pitch);
            for (int i = 0; i < NM; i++) begin
              msum_d[i] = msum_q[i] + SW'(motor_in[i]);
            end
            count_d = count_q + 1'b1;
          end
          if ((elapsed >= TIME_W'(cfg_i.sample_window_ms)) && (count_d != '0)) begin
            win_end  = 1'b1;
            clear_d  = 1'b1;
            wide_d   = 1'b0;
            phase_d  = hvtrim_pkg::PH_DONE;
            buz_d    = 1'b1;
            buz_dl_d = in_q.now_ms + TIME_W'(cfg_i.buzzer_ms);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= hvtrim_pkg::PH_WAIT;
      start_q     <= '0;
      count_q     <= '0;
      roll_sum_q  <= '0;
      pitch_sum_q <= '0;
      for (int i = 0; i < NM; i++) begin
        msum_q[i] <= '0;
      end
      roll_off_q  <= hvtrim_pkg::CFG_RST.def_roll;
      pitch_off_q <= hvtrim_pkg::CFG_RST.def_pitch;
      hover_q[0]  <= hvtrim_pkg::CFG_RST.def_hover_front[DRV_W-1:0];
      hover_q[1]  <= hvtrim_pkg::CFG_RST.def_hover_front[2*DRV_W-1:DRV_W];
      hover_q[2]  <= hvtrim_pkg::CFG_RST.def_hover_back[DRV_W-1:0];
      hover_q[3]  <= hvtrim_pkg::CFG_RST.def_hover_back[2*DRV_W-1:DRV_W];
      buz_q       <= 1'b0;
      buz_dl_q    <= '0;
      wide_q      <= 1'b1;
      clear_q     <= 1'b0;
    end else if (cmd_i.eval) begin
      phase_q     <= phase_d;
      start_q     <= start_d;
      count_q     <= count_d;
      roll_sum_q  <= roll_sum_d;
      pitch_sum_q <= pitch_sum_d;
      msum_q      <= msum_d;
      roll_off_q  <= roll_off_d;
      pitch_off_q <= pitch_off_d;
      hover_q     <= hover_d;
      buz_q       <= buz_d;
      buz_dl_q    <= buz_dl_d;
      wide_q      <= wide_d;
      clear_q     <= clear_d;
    end else if (cmd_i.div_store) begin
      case (cmd_i.qsel)
        hvtrim_pkg::QSEL_ROLL:  roll_off_q  <= quo;
        hvtrim_pkg::QSEL_PITCH: pitch_off_q <= quo;
        hvtrim_pkg::QSEL_LF:    hover_q[0]  <= quo;
        hvtrim_pkg::QSEL_RF:    hover_q[1]  <= quo;
        hvtrim_pkg::QSEL_LB:    hover_q[2]  <= quo;
        hvtrim_pkg::QSEL_RB:    hover_q[3]  <= quo;
        default: begin
        end
      endcase
    end
  end

  // Dividend select
  always_comb begin
    case (cmd_i.qsel)
      hvtrim_pkg::QSEL_ROLL:  dvd = roll_sum_q;
      hvtrim_pkg::QSEL_PITCH: dvd = pitch_sum_q;
      hvtrim_pkg::QSEL_LF:    dvd = msum_q[0];
      hvtrim_pkg::QSEL_RF:    dvd = msum_q[1];
      hvtrim_pkg::QSEL_LB:    dvd = msum_q[2];
      hvtrim_pkg::QSEL_RB:    dvd = msum_q[3];
      default:                dvd = '0;
    endcase
  end

  hvtrim_div #(
    .NW (SW),
    .DW (CW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dvd),
    .divisor_i  (count_q),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  assign sts_o.need_div = win_end;
  assign sts_o.div_done = div_done;

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.pad                 <= 1'b0;
      out_q.phase               <= phase_q;
      out_q.buzzer              <= buz_q;
      out_q.roll_trim           <= roll_off_q;
      out_q.pitch_trim          <= pitch_off_q;
      out_q.corrected_roll      <= CORR_W'(in_q.roll) - CORR_W'(roll_off_q);
      out_q.corrected_pitch     <= CORR_W'(in_q.pitch) - CORR_W'(pitch_off_q);
      out_q.hover_lf            <= hover_q[0];
      out_q.hover_rf            <= hover_q[1];
      out_q.hover_lb            <= hover_q[2];
      out_q.hover_rb            <= hover_q[3];
      out_q.clear_integrals     <= clear_q;
      out_q.wide_integral_limit <= wide_q;
    end
  end

  assign out_data_o = out_q;

endmodule

### rtl/core/hvtrim_ctrl.sv
// Controller: sequences capture, tick update, the six averaging divisions and result hand-off.
// Depends on hvtrim_pkg; commands hvtrim_dp.
module hvtrim_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output hvtrim_pkg::cmd_t cmd_o,
  input  hvtrim_pkg::sts_t sts_i
);

  hvtrim_pkg::ctrl_state_e state_q, state_d;
  hvtrim_pkg::qsel_e       sel_q, sel_d;
  logic                    out_valid_q, out_valid_d;
  logic                    load;

  assign load = (state_q == hvtrim_pkg::ST_EMIT) && (!out_valid_q || out_ready_i);

  // Next state
  always_comb begin
    state_d     = state_q;
    sel_d       = sel_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (load) begin
      out_valid_d = 1'b1;
    end
    case (state_q)
      hvtrim_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = hvtrim_pkg::ST_EVAL;
        end
      end
      hvtrim_pkg::ST_EVAL: begin
        if (sts_i.need_div) begin
          state_d = hvtrim_pkg::ST_DIV_START;
          sel_d   = hvtrim_pkg::QSEL_ROLL;
        end else begin
          state_d = hvtrim_pkg::ST_EMIT;
        end
      end
      hvtrim_pkg::ST_DIV_START: begin
        state_d = hvtrim_pkg::ST_DIV_WAIT;
      end
      hvtrim_pkg::ST_DIV_WAIT: begin
        if (sts_i.div_done) begin
          state_d = hvtrim_pkg::ST_DIV_START;
          case (sel_q)
            hvtrim_pkg::QSEL_ROLL:  sel_d = hvtrim_pkg::QSEL_PITCH;
            hvtrim_pkg::QSEL_PITCH: sel_d = hvtrim_pkg::QSEL_LF;
            hvtrim_pkg::QSEL_LF:    sel_d = hvtrim_pkg::QSEL_RF;
            hvtrim_pkg::QSEL_RF:    sel_d = hvtrim_pkg::QSEL_LB;
            hvtrim_pkg::QSEL_LB:    sel_d = hvtrim_pkg::QSEL_RB;
            default:                state_d = hvtrim_pkg::ST_EMIT;
          endcase
        end
      end
      hvtrim_pkg::ST_EMIT: begin
        if (load) begin
          state_d = hvtrim_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = hvtrim_pkg::ST_IDLE;
      end
    endcase
  end

  // Commands
  always_comb begin
    in_ready_o       = (state_q == hvtrim_pkg::ST_IDLE);
    out_valid_o      = out_valid_q;
    cmd_o.capture    = (state_q == hvtrim_pkg::ST_IDLE) && in_valid_i;
    cmd_o.eval       = (state_q == hvtrim_pkg::ST_EVAL);
    cmd_o.div_start  = (state_q == hvtrim_pkg::ST_DIV_START);
    cmd_o.qsel       = sel_q;
    cmd_o.div_store  = (state_q == hvtrim_pkg::ST_DIV_WAIT) && sts_i.div_done;
    cmd_o.out_load   = load;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hvtrim_pkg::ST_IDLE;
      sel_q       <= hvtrim_pkg::QSEL_ROLL;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sel_q       <= sel_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

### rtl/core/hover_trim_calibration_sequencer_top.sv
// Top level of the hover trim calibration sequencer: register file and stream ports.
// Depends on hvtrim_pkg, hvtrim_ctrl and hvtrim_dp.
//
// One request per control tick goes in, one result comes out. A request is taken only
// while the block is idle; an ordinary tick passes through the evaluate state to the emit
// state, where the result register loads once the output side is free, and the next
// request can be taken the cycle after the result register loads. The tick that closes
// the sampling window also runs six averages through one shared bit-serial divider, one
// quotient bit per cycle over DRV_W+clog2(MAX_SAMPLES+1) bits, each average started in
// its own start state and stored when the divider reports done. A result waiting in the
// output register does not keep a new request from being taken. Registers are written
// over the APB-style port at byte address 4*index and take effect as described per
// register: default offsets and drives load only on reset or on a restart request.
module hover_trim_calibration_sequencer_top #(
  parameter int unsigned MAX_SAMPLES = hvtrim_pkg::MAX_SAMPLES_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [hvtrim_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [hvtrim_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [hvtrim_pkg::APB_DATA_W-1:0]    prdata,
  output logic                                 pready,
  // requests
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // now_ms, in_normal_flight, armed, height_cm, roll, pitch,
  // motor_lf, motor_rf, motor_lb, motor_rb, zero pad
  input  logic [hvtrim_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // action
  input  logic [0:0]                           s_axis_tuser,
  // results
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // phase, buzzer, roll_trim, pitch_trim, corrected_roll, corrected_pitch,
  // hover_lf, hover_rf, hover_lb, hover_rb, clear_integrals, wide_integral_limit, zero pad
  output logic [hvtrim_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

  localparam int unsigned DRV_W = hvtrim_pkg::DRV_W;

  hvtrim_pkg::cfg_t     cfg_q;
  hvtrim_pkg::reg_idx_e idx;
  logic                 wr;
  hvtrim_pkg::cmd_t     cmd;
  hvtrim_pkg::sts_t     sts;

  assign pready = 1'b1;
  assign idx    = hvtrim_pkg::reg_idx_e'(paddr[hvtrim_pkg::APB_ADDR_W-1:2]);
  assign wr     = psel && penable && pwrite;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= hvtrim_pkg::CFG_RST;
    end else if (wr) begin
      case (idx)
        hvtrim_pkg::REG_TRIGGER_HEIGHT: cfg_q.trigger_height   <= pwdata[DRV_W-1:0];
        hvtrim_pkg::REG_STABLE_WAIT:    cfg_q.stable_wait_ms   <= pwdata[DRV_W-1:0];
        hvtrim_pkg::REG_SAMPLE_WINDOW:  cfg_q.sample_window_ms <= pwdata[DRV_W-1:0];
        hvtrim_pkg::REG_BUZZER_MS:      cfg_q.buzzer_ms        <= pwdata[DRV_W-1:0];
        hvtrim_pkg::REG_DEF_ROLL:       cfg_q.def_roll         <= pwdata[DRV_W-1:0];
        hvtrim_pkg::REG_DEF_PITCH:      cfg_q.def_pitch        <= pwdata[DRV_W-1:0];
        hvtrim_pkg::REG_DEF_HOVER_F:    cfg_q.def_hover_front  <= pwdata[2*DRV_W-1:0];
        hvtrim_pkg::REG_DEF_HOVER_B:    cfg_q.def_hover_back   <= pwdata[2*DRV_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Register reads, raw bits zero extended
  always_comb begin
    case (idx)
      hvtrim_pkg::REG_TRIGGER_HEIGHT: prdata = {16'd0, cfg_q.trigger_height};
      hvtrim_pkg::REG_STABLE_WAIT:    prdata = {16'd0, cfg_q.stable_wait_ms};
      hvtrim_pkg::REG_SAMPLE_WINDOW:  prdata = {16'd0, cfg_q.sample_window_ms};
      hvtrim_pkg::REG_BUZZER_MS:      prdata = {16'd0, cfg_q.buzzer_ms};
      hvtrim_pkg::REG_DEF_ROLL:       prdata = {16'd0, cfg_q.def_roll};
      hvtrim_pkg::REG_DEF_PITCH:      prdata = {16'd0, cfg_q.def_pitch};
      hvtrim_pkg::REG_DEF_HOVER_F:    prdata = cfg_q.def_hover_front;
      hvtrim_pkg::REG_DEF_HOVER_B:    prdata = cfg_q.def_hover_back;
      default:                        prdata = '0;
    endcase
  end

  hvtrim_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  hvtrim_dp #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (s_axis_tdata),
    .in_action_i (s_axis_tuser[0]),
    .out_data_o  (m_axis_tdata)
  );

endmodule

### rtl/core/hvtrim_checker.sv
// Port-level checks of the hover trim calibration sequencer, bound to the top level.
// Depends on hvtrim_pkg for the result layout.
module hvtrim_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               s_axis_tvalid,
  input logic                               s_axis_tready,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready,
  input logic [hvtrim_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  hvtrim_pkg::out_t res;
  assign res = hvtrim_pkg::out_t'(m_axis_tdata);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // One request at a time
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while busy");

  // The integrator clear only comes with the calibration just finished
  a_clear_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.clear_integrals |->
      (res.phase == hvtrim_pkg::PH_DONE) && !res.wide_integral_limit)
    else $error("clear pulse outside done phase");

  // The wide limit is only dropped once calibration is done
  a_wide_before_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (res.phase != hvtrim_pkg::PH_DONE) |-> res.wide_integral_limit)
    else $error("wide limit dropped before done");

endmodule

bind hover_trim_calibration_sequencer_top hvtrim_checker u_hvtrim_checker (.*);

### test/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for hover_trim_calibration_sequencer_top: stream requests in,
// one result per request out, compared against an in-bench model of the calibration
// sequence. Depends on hvtrim_pkg and the block's RTL only.
module tb;
  import hvtrim_pkg::*;

  localparam int unsigned SAMPLE_CAP  = MAX_SAMPLES_DEF;
  localparam int unsigned CYCLE_LIMIT = 3000000;
  localparam int unsigned TAIL_CYCLES = 250;

  typedef struct {
    logic act;
    in_t  data;
    bit   hold;
  } pending_req_t;

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // configuration port
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [APB_ADDR_W-1:0] paddr   = '0;
  logic [APB_DATA_W-1:0] pwdata  = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // request and result streams
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic [0:0]             s_axis_tuser  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  // stimulus bookkeeping
  pending_req_t pending_reqs[$];
  pending_req_t next_req;
  out_t         expected_results[$];
  out_t         want_res;
  out_t         got_res;
  bit           holding_req = 1'b0;
  bit           hold_next   = 1'b0;
  int unsigned  src_idle_pct   = 0;
  int unsigned  sink_stall_pct = 0;
  int unsigned  items_queued   = 0;
  int unsigned  cycle_count    = 0;
  int           fail_count     = 0;
  logic [31:0]  clock_ms       = '0;

  // calibration model state
  cfg_t                    shadow_cfg;
  phase_e                  cal_phase;
  logic [TIME_W-1:0]       phase_t0;
  int unsigned             n_samples;
  longint                  acc_roll;
  longint                  acc_pitch;
  longint                  acc_motor[NUM_MOTORS];
  logic signed [DRV_W-1:0] off_roll;
  logic signed [DRV_W-1:0] off_pitch;
  logic signed [DRV_W-1:0] hover_drv[NUM_MOTORS];
  logic                    buz_on;
  logic [TIME_W-1:0]       buz_until;
  logic                    wide_lim;

  hover_trim_calibration_sequencer_top #(
    .MAX_SAMPLES(SAMPLE_CAP)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Calibration model
  // ---------------------------------------------------------------------------

  // reset / restart values; defaults come from the register copy
  function automatic void load_defaults();
    cal_phase = PH_WAIT;
    phase_t0  = '0;
    n_samples = 0;
    acc_roll  = 0;
    acc_pitch = 0;
    foreach (acc_motor[i]) acc_motor[i] = 0;
    off_roll     = shadow_cfg.def_roll;
    off_pitch    = shadow_cfg.def_pitch;
    hover_drv[0] = shadow_cfg.def_hover_front[15:0];
    hover_drv[1] = shadow_cfg.def_hover_front[31:16];
    hover_drv[2] = shadow_cfg.def_hover_back[15:0];
    hover_drv[3] = shadow_cfg.def_hover_back[31:16];
    buz_on    = 1'b0;
    buz_until = '0;
    wide_lim  = 1'b1;
  endfunction

  // one control tick: advance the sequence, return the result it gives
  function automatic out_t trim_predict(input logic act, input in_t req);
    out_t              res;
    logic [TIME_W-1:0] elapsed;
    logic              pulse;
    int                roll_v;
    int                pitch_v;
    int                motor_v[NUM_MOTORS];
    roll_v     = $signed(req.roll);
    pitch_v    = $signed(req.pitch);
    motor_v[0] = $signed(req.motor_lf);
    motor_v[1] = $signed(req.motor_rf);
    motor_v[2] = $signed(req.motor_lb);
    motor_v[3] = $signed(req.motor_rb);
    pulse      = 1'b0;
    elapsed    = req.now_ms - phase_t0;
    if (act == ACT_RESTART) begin
      load_defaults();
    end else begin
      // plain unsigned compare, a wrapped deadline ends at once
      if (buz_on && req.now_ms >= buz_until) buz_on = 1'b0;
      case (cal_phase)
        PH_WAIT: begin
          if (req.in_normal_flight && req.armed &&
              $signed(req.height_cm) >= $signed(shadow_cfg.trigger_height)) begin
            cal_phase = PH_STAB;
            phase_t0  = req.now_ms;
          end
        end
        PH_STAB: begin
          if (elapsed >= {16'd0, shadow_cfg.stable_wait_ms}) begin
            cal_phase = PH_SAMPLE;
            phase_t0  = req.now_ms;
            n_samples = 0;
            acc_roll  = 0;
            acc_pitch = 0;
            foreach (acc_motor[i]) acc_motor[i] = 0;
            buz_on    = 1'b1;
            buz_until = req.now_ms + {16'd0, shadow_cfg.buzzer_ms};
          end
        end
        PH_SAMPLE: begin
          // samples past the cap are dropped, the window still closes on time
          if (n_samples < SAMPLE_CAP) begin
            acc_roll  += roll_v;
            acc_pitch += pitch_v;
            foreach (acc_motor[i]) acc_motor[i] += motor_v[i];
            n_samples++;
          end
          if (elapsed >= {16'd0, shadow_cfg.sample_window_ms} && n_samples > 0) begin
            // integer division truncates toward zero
            off_roll  = DRV_W'(acc_roll / longint'(n_samples));
            off_pitch = DRV_W'(acc_pitch / longint'(n_samples));
            foreach (hover_drv[i]) hover_drv[i] = DRV_W'(acc_motor[i] / longint'(n_samples));
            pulse     = 1'b1;
            wide_lim  = 1'b0;
            cal_phase = PH_DONE;
            buz_on    = 1'b1;
            buz_until = req.now_ms + {16'd0, shadow_cfg.buzzer_ms};
          end
        end
        default: ;
      endcase
    end
    res                     = '0;
    res.phase               = cal_phase;
    res.buzzer              = buz_on;
    res.roll_trim           = off_roll;
    res.pitch_trim          = off_pitch;
    res.corrected_roll      = CORR_W'(roll_v - int'(off_roll));
    res.corrected_pitch     = CORR_W'(pitch_v - int'(off_pitch));
    res.hover_lf            = hover_drv[0];
    res.hover_rf            = hover_drv[1];
    res.hover_lb            = hover_drv[2];
    res.hover_rb            = hover_drv[3];
    res.clear_integrals     = pulse;
    res.wide_integral_limit = wide_lim;
    return res;
  endfunction

  // register copy follows every APB write
  always @(posedge clk_i) begin
    if (rst_ni && psel && penable && pwrite && pready) begin
      case (reg_idx_e'(paddr[4:2]))
        REG_TRIGGER_HEIGHT: shadow_cfg.trigger_height   = pwdata[15:0];
        REG_STABLE_WAIT:    shadow_cfg.stable_wait_ms   = pwdata[15:0];
        REG_SAMPLE_WINDOW:  shadow_cfg.sample_window_ms = pwdata[15:0];
        REG_BUZZER_MS:      shadow_cfg.buzzer_ms        = pwdata[15:0];
        REG_DEF_ROLL:       shadow_cfg.def_roll         = pwdata[15:0];
        REG_DEF_PITCH:      shadow_cfg.def_pitch        = pwdata[15:0];
        REG_DEF_HOVER_F:    shadow_cfg.def_hover_front  = pwdata;
        REG_DEF_HOVER_B:    shadow_cfg.def_hover_back   = pwdata;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Request driver and result monitor
  // ---------------------------------------------------------------------------

  // request driver; a held request waits until all results are back
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      holding_req = 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.push_back(trim_predict(s_axis_tuser[0], in_t'(s_axis_tdata)));
        holding_req = 1'b0;
      end
      if (!holding_req) begin
        if (pending_reqs.size() != 0 &&
            !(src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) &&
            !(pending_reqs[0].hold && expected_results.size() != 0)) begin
          next_req = pending_reqs.pop_front();
          s_axis_tdata  <= next_req.data;
          s_axis_tuser  <= next_req.act;
          s_axis_tvalid <= 1'b1;
          holding_req = 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] want, got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // result monitor with random back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_res = out_t'(m_axis_tdata);
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0h", $time, m_axis_tdata);
          fail_count++;
        end else begin
          want_res = expected_results.pop_front();
          check_field("phase", want_res.phase, got_res.phase);
          check_field("buzzer", want_res.buzzer, got_res.buzzer);
          check_field("roll_trim", want_res.roll_trim, got_res.roll_trim);
          check_field("pitch_trim", want_res.pitch_trim, got_res.pitch_trim);
          check_field("corrected_roll", want_res.corrected_roll, got_res.corrected_roll);
          check_field("corrected_pitch", want_res.corrected_pitch, got_res.corrected_pitch);
          check_field("hover_lf", want_res.hover_lf, got_res.hover_lf);
          check_field("hover_rf", want_res.hover_rf, got_res.hover_rf);
          check_field("hover_lb", want_res.hover_lb, got_res.hover_lb);
          check_field("hover_rb", want_res.hover_rb, got_res.hover_rb);
          check_field("clear_integrals", want_res.clear_integrals, got_res.clear_integrals);
          check_field("wide_integral_limit", want_res.wide_integral_limit,
                      got_res.wide_integral_limit);
        end
      end
      m_axis_tready <= (sink_stall_pct == 0) || ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // run time guard
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  task automatic apb_write(input reg_idx_e idx, input logic [31:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic write_cfg(input int trig, stab, win, buz, droll, dpitch,
                           input logic [31:0] hf, hb);
    apb_write(REG_TRIGGER_HEIGHT, 32'(trig));
    apb_write(REG_STABLE_WAIT, 32'(stab));
    apb_write(REG_SAMPLE_WINDOW, 32'(win));
    apb_write(REG_BUZZER_MS, 32'(buz));
    apb_write(REG_DEF_ROLL, 32'(droll));
    apb_write(REG_DEF_PITCH, 32'(dpitch));
    apb_write(REG_DEF_HOVER_F, hf);
    apb_write(REG_DEF_HOVER_B, hb);
  endtask

  // block is idle once nothing is queued, held or outstanding
  task automatic wait_drain();
    while (pending_reqs.size() != 0 || holding_req || expected_results.size() != 0)
      @(posedge clk_i);
  endtask

  function automatic int rand_angle(input int ext_pct);
    if ($urandom_range(99) < ext_pct) return $urandom_range(1) ? 18000 : -18000;
    return int'($urandom_range(36000)) - 18000;
  endfunction

  function automatic int rand_drive(input int ext_pct);
    if ($urandom_range(99) < ext_pct) return $urandom_range(1) ? 32767 : -32768;
    return int'($signed(16'($urandom)));
  endfunction

  function automatic in_t make_req(input logic [31:0] now, input logic fly, arm,
                                   input int h, r, p, lf, rf, lb, rb);
    in_t d;
    d                  = '0;
    d.now_ms           = now;
    d.in_normal_flight = fly;
    d.armed            = arm;
    d.height_cm        = DRV_W'(h);
    d.roll             = DRV_W'(r);
    d.pitch            = DRV_W'(p);
    d.motor_lf         = DRV_W'(lf);
    d.motor_rf         = DRV_W'(rf);
    d.motor_lb         = DRV_W'(lb);
    d.motor_rb         = DRV_W'(rb);
    return d;
  endfunction

  // random content stamped with the running millisecond time
  function automatic in_t stream_fields(input int ext_pct);
    return make_req(clock_ms, $urandom_range(1), $urandom_range(1), rand_drive(ext_pct),
                    rand_angle(ext_pct), rand_angle(ext_pct), rand_drive(ext_pct),
                    rand_drive(ext_pct), rand_drive(ext_pct), rand_drive(ext_pct));
  endfunction

  task automatic push_req(input logic act, input in_t d);
    pending_req_t pr;
    pr.act  = act;
    pr.data = d;
    pr.hold = hold_next || ($urandom_range(63) == 0);
    hold_next = 1'b0;
    pending_reqs.push_back(pr);
    items_queued++;
  endtask

  // restart, wait, trigger, stabilize, sample, done; sometimes cut short by a restart
  task automatic push_calibration(input int ext_pct);
    in_t         d;
    int          trig;
    int          span;
    int          elapsed;
    int          step_max;
    int          stepv;
    int unsigned blocker;
    trig = $signed(shadow_cfg.trigger_height);
    if ($urandom_range(7) == 0) clock_ms = 32'hFFFF_FFFF - $urandom_range(70000);
    push_req(ACT_RESTART, stream_fields(ext_pct));
    // waiting ticks that must not trigger
    repeat ($urandom_range(2)) begin
      clock_ms += $urandom_range(50);
      d = stream_fields(ext_pct);
      blocker = $urandom_range(2);
      if (blocker == 0 || (blocker == 2 && trig == -32768)) begin
        d.in_normal_flight = 1'b0;
      end else if (blocker == 1) begin
        d.armed = 1'b0;
      end else begin
        d.height_cm = DRV_W'(int'($urandom_range(trig + 32767)) - 32768);
      end
      push_req(ACT_TICK, d);
    end
    clock_ms += $urandom_range(50);
    d = stream_fields(ext_pct);
    d.in_normal_flight = 1'b1;
    d.armed            = 1'b1;
    d.height_cm        = DRV_W'(trig + int'($urandom_range(32767 - trig)));
    push_req(ACT_TICK, d);
    // stabilize (stage 0) and sample (stage 1), each until its time has run out
    for (int stage = 0; stage < 2; stage++) begin
      span     = (stage == 0) ? int'(shadow_cfg.stable_wait_ms)
                              : int'(shadow_cfg.sample_window_ms);
      step_max = 2 * span / int'($urandom_range(1, 10)) + 1;
      elapsed  = 0;
      while (1) begin
        if ($urandom_range(99) < 3) begin
          push_req(ACT_RESTART, stream_fields(ext_pct));
          return;
        end
        stepv     = $urandom_range(step_max);
        clock_ms += stepv;
        elapsed  += stepv;
        push_req(ACT_TICK, stream_fields(ext_pct));
        if (elapsed >= span) break;
      end
    end
    repeat ($urandom_range(1, 3)) begin
      clock_ms += $urandom_range(2 * int'(shadow_cfg.buzzer_ms) + 1);
      push_req(ACT_TICK, stream_fields(ext_pct));
    end
  endtask

  // stray requests: time jumps, restarts, arbitrary flags
  task automatic push_noise(input int ext_pct);
    repeat ($urandom_range(1, 4)) begin
      if ($urandom_range(7) == 0) clock_ms = $urandom;
      else clock_ms += $urandom_range(5000);
      push_req(($urandom_range(3) == 0) ? ACT_RESTART : ACT_TICK, stream_fields(ext_pct));
    end
  endtask

  task automatic push_random_mix(input int unsigned n, input int ext_pct);
    int unsigned start;
    start = items_queued;
    while (items_queued - start < n) begin
      if ($urandom_range(9) < 8) push_calibration(ext_pct);
      else push_noise(ext_pct);
    end
  endtask

  task automatic write_random_cfg();
    write_cfg(int'($urandom_range(300)) - 100, $urandom_range(4000), $urandom_range(2000),
              $urandom_range(800), rand_angle(20), rand_angle(20), $urandom, $urandom);
  endtask

  initial begin
    shadow_cfg = CFG_RST;
    load_defaults();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed part, reset configuration
    push_req(ACT_TICK, make_req(32'hFFFF_FFFF, 0, 0, -32768, -18000, 18000,
                                -32768, 32767, 0, -1));
    hold_next = 1'b1;
    push_req(ACT_RESTART, make_req(0, 1, 1, 32767, 18000, -18000, 1, 2, 3, 4));
    push_req(ACT_TICK, make_req(0, 1, 1, 79, 100, -100, 0, 0, 0, 0));
    push_req(ACT_TICK, make_req(10, 1, 0, 32767, 0, 0, 0, 0, 0, 0));
    push_req(ACT_TICK, make_req(20, 0, 1, 32767, 0, 0, 0, 0, 0, 0));
    // trigger exactly at the threshold height
    push_req(ACT_TICK, make_req(1000, 1, 1, 80, 0, 0, 0, 0, 0, 0));
    push_req(ACT_TICK, make_req(3999, 0, 0, -5, 17, -17, 5, 5, 5, 5));
    push_req(ACT_TICK, make_req(4000, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // samples whose averages truncate toward zero
    push_req(ACT_TICK, make_req(4050, 1, 1, 0, -18000, 18000, -32768, 32767, -32768, 32767));
    push_req(ACT_TICK, make_req(4100, 1, 1, 0, 17999, -18000, -32768, 32767, 1, -1));
    push_req(ACT_TICK, make_req(5000, 1, 1, 0, -2, 1, -32768, 32767, 0, 0));
    push_req(ACT_TICK, make_req(5050, 1, 1, 0, 18000, -18000, 0, 0, 0, 0));
    push_req(ACT_TICK, make_req(5100, 0, 0, 0, -18000, 18000, 0, 0, 0, 0));
    push_req(ACT_RESTART, make_req(5200, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // sampling starts just before the time wraps: buzzer deadline and window wrap too
    push_req(ACT_TICK, make_req(32'hFFFF_F408, 1, 1, 32767, 0, 0, 0, 0, 0, 0));
    push_req(ACT_TICK, make_req(32'hFFFF_FFD0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    push_req(ACT_TICK, make_req(32'hFFFF_FFE0, 0, 0, 0, 18000, 18000, 100, -100, 7, -7));
    push_req(ACT_TICK, make_req(32'h0000_0010, 0, 0, 0, -18000, -17999, 9, 9, 9, 9));
    push_req(ACT_TICK, make_req(32'h0000_0400, 0, 0, 0, 5, -5, -3, 3, -1, 1));
    push_req(ACT_TICK, make_req(32'h0000_0400, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // restart in the middle of sampling
    push_req(ACT_RESTART, make_req(32'h0000_0050, 1, 1, 0, 0, 0, 0, 0, 0, 0));
    push_req(ACT_TICK, make_req(100, 1, 1, 1000, 0, 0, 0, 0, 0, 0));
    push_req(ACT_TICK, make_req(3100, 1, 1, 1000, 0, 0, 0, 0, 0, 0));
    push_req(ACT_TICK, make_req(3200, 1, 1, 1000, 1234, -4321, 11, 22, 33, 44));
    push_req(ACT_RESTART, make_req(3250, 1, 1, 1000, 0, 0, 0, 0, 0, 0));
    push_req(ACT_TICK, make_req(3300, 0, 0, 0, -1, 1, 0, 0, 0, 0));
    wait_drain();

    // random settings, sender idling
    write_random_cfg();
    src_idle_pct   = 56;
    sink_stall_pct = 0;
    push_random_mix(250, 10);
    wait_drain();

    // lowest trigger, zero waits, longest buzzer, receiver stalling
    write_cfg(-32768, 0, 0, 65535, -18000, 18000, 32'h7FFF_8000, 32'h8000_7FFF);
    src_idle_pct   = 0;
    sink_stall_pct = 56;
    push_random_mix(250, 15);
    wait_drain();

    // highest trigger, longest waits, zero buzzer, both sides idling
    write_cfg(32767, 65535, 65535, 0, 18000, -18000, 32'hFFFF_FFFF, 32'h0000_0000);
    src_idle_pct   = 20;
    sink_stall_pct = 20;
    push_random_mix(250, 15);
    wait_drain();

    // no stabilize wait, longest window, no idling
    write_cfg($urandom_range(200), 0, 65535, $urandom_range(500), rand_angle(0), rand_angle(0),
              $urandom, $urandom);
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    push_random_mix(100, 20);
    wait_drain();

    // fresh settings under each idling pattern in turn
    for (int seg = 0; seg < 4; seg++) begin
      write_random_cfg();
      src_idle_pct   = (seg == 1) ? 56 : (seg == 3) ? 20 : 0;
      sink_stall_pct = (seg == 2) ? 56 : (seg == 3) ? 20 : 0;
      push_random_mix(90, 10);
      wait_drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/hvtrim_pkg.sv
rtl/core/hvtrim_div.sv
rtl/core/hvtrim_dp.sv
rtl/core/hvtrim_ctrl.sv
rtl/core/hover_trim_calibration_sequencer_top.sv
rtl/core/hvtrim_checker.sv
test/tb.sv
